FILE: rtl/core/pmpe_pkg.sv
package pmpe_pkg;

  localparam int unsigned VAL_W = 32;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [VAL_W-1:0] DEC_RADIX = VAL_W'(10);

  typedef enum logic [1:0] {
    OPC_PLUS  = 2'd0,
    OPC_MINUS = 2'd1,
    OPC_OPEN  = 2'd2
  } opc_e;

  // how the operator shift line moves on one word
  typedef enum logic [1:0] {
    OSH_POP2 = 2'd0,
    OSH_POP1 = 2'd1,
    OSH_HOLD = 2'd2,
    OSH_PUSH = 2'd3
  } osh_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    error;
  } out_t;

  // new top-of-stack cache for the value stack, plus the entry spilled to RAM
  typedef struct packed {
    logic [2:0][VAL_W-1:0] top;
    logic [VAL_W-1:0]      spill;
  } vupd_t;

  typedef struct packed {
    logic push;
    opc_e code;
    osh_e shift;
  } oupd_t;

endpackage

FILE: rtl/core/plus_minus_paren_evaluator.sv
// A word is taken into the input register and evaluated from there; its result,
// if it is the last character, is pushed into the output queue and presented on out_valid_o.
// One character per cycle is taken. Last characters wait only while the
// two-entry output queue is full.
// Reset (async, active low): value stack holds a single zero, operator stack empty,
// no pending number, error clear. The same state is restored after every last char.
module plus_minus_paren_evaluator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pmpe_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pmpe_pkg::out_t   out_data_o
);

  import pmpe_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic                  s1_valid_q;
  in_t                   s1_q;
  logic                  fire;
  logic                  ofull;

  logic [VAL_W-1:0]      pend_q, pend_d;
  logic                  pv_q, pv_d;
  logic                  err_q, err_d;

  logic [CW-1:0]         vcnt, vcnt_d;
  logic [3:0][VAL_W-1:0] vwin;
  vupd_t                 vupd;
  logic [CW-1:0]         ocnt, ocnt_d;
  logic [2:0][1:0]       otop;
  oupd_t                 oupd;
  out_t                  res;

  logic [1:0]            oq_cnt_q;
  out_t                  oq_q [2];
  logic                  oq_push, oq_pop;

  // input register
  assign ofull      = (oq_cnt_q == 2'd2);
  assign fire       = s1_valid_q && (!s1_q.last || !ofull);
  assign in_ready_o = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
  end

  pmpe_eval #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_eval (
    .in_i    (s1_q),
    .vcnt_i  (vcnt),
    .vwin_i  (vwin),
    .ocnt_i  (ocnt),
    .otop_i  (otop),
    .pend_i  (pend_q),
    .pv_i    (pv_q),
    .err_i   (err_q),
    .vcnt_d_o(vcnt_d),
    .vupd_o  (vupd),
    .ocnt_d_o(ocnt_d),
    .oupd_o  (oupd),
    .pend_d_o(pend_d),
    .pv_d_o  (pv_d),
    .err_d_o (err_d),
    .res_o   (res)
  );

  pmpe_vstack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_vstack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (fire),
    .cnt_d_i(vcnt_d),
    .vupd_i (vupd),
    .cnt_o  (vcnt),
    .win_o  (vwin)
  );

  pmpe_ostack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ostack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (fire),
    .cnt_d_i(ocnt_d),
    .oupd_i (oupd),
    .cnt_o  (ocnt),
    .top_o  (otop)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pv_q   <= 1'b0;
      err_q  <= 1'b0;
    end else if (fire) begin
      pend_q <= pend_d;
      pv_q   <= pv_d;
      err_q  <= err_d;
    end
  end

  // two-entry output queue, head in slot 0
  assign oq_push = fire && s1_q.last;
  assign oq_pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_cnt_q <= 2'd0;
    end else if (oq_push && !oq_pop) begin
      oq_cnt_q <= oq_cnt_q + 2'd1;
    end else if (oq_pop && !oq_push) begin
      oq_cnt_q <= oq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push && !oq_pop) begin
      oq_q[oq_cnt_q[0]] <= res;
    end else if (oq_pop && !oq_push) begin
      oq_q[0] <= oq_q[1];
    end else if (oq_pop && oq_push) begin
      if (oq_cnt_q == 2'd1) begin
        oq_q[0] <= res;
      end else begin
        oq_q[0] <= oq_q[1];
        oq_q[1] <= res;
      end
    end
  end

  assign out_valid_o = (oq_cnt_q != 2'd0);
  assign out_data_o  = oq_q[0];

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_q.last |=> out_valid_o)
    else $error("last character produced no result");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_q.last |=> (vcnt == CW'(1)) && (ocnt == '0) && !err_q && !pv_q)
    else $error("state not cleared after expression end");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vcnt <= CW'(STACK_DEPTH)) && (ocnt <= CW'(STACK_DEPTH)))
    else $error("stack count beyond depth");

endmodule

FILE: rtl/core/pmpe_ram.sv
module pmpe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pmpe_vstack.sv
module pmpe_vstack #(
  parameter int unsigned STACK_DEPTH = 64,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1),
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              upd_i,
  input  logic [CW-1:0]                     cnt_d_i,
  input  pmpe_pkg::vupd_t                   vupd_i,
  output logic [CW-1:0]                     cnt_o,
  output logic [3:0][pmpe_pkg::VAL_W-1:0]   win_o
);

  import pmpe_pkg::*;

  // Top three entries live in flops, the rest in RAM. The RAM read port
  // always prefetches the entry just below the cached three.
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [2:0][VAL_W-1:0]     top_q;
  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [VAL_W-1:0]          ram_rdata;
  logic                      fwd_q;
  logic [VAL_W-1:0]          fwd_data_q;

  assign cnt_d = upd_i ? cnt_d_i : cnt_q;
  assign we    = upd_i && (cnt_d_i == cnt_q + CW'(1)) && (cnt_q >= CW'(3));
  assign waddr = AW'(cnt_q - CW'(3));
  assign raddr = AW'(cnt_d - CW'(4));

  pmpe_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(vupd_i.spill),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CW'(1);
      top_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (upd_i) begin
        top_q <= vupd_i.top;
      end
      fwd_q <= we && (waddr == raddr);
    end
  end

  // a spill lands on the address being prefetched
  always_ff @(posedge clk_i) begin
    fwd_data_q <= vupd_i.spill;
  end

  assign cnt_o = cnt_q;
  assign win_o = {(fwd_q ? fwd_data_q : ram_rdata), top_q};

endmodule

FILE: rtl/core/pmpe_ostack.sv
module pmpe_ostack #(
  parameter int unsigned STACK_DEPTH = 64,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_i,
  input  logic [CW-1:0]        cnt_d_i,
  input  pmpe_pkg::oupd_t      oupd_i,
  output logic [CW-1:0]        cnt_o,
  output logic [2:0][1:0]      top_o
);

  import pmpe_pkg::*;

  // shift-line stack, slot 0 is the top
  logic [CW-1:0] cnt_q;
  logic [1:0]    ops_q [STACK_DEPTH];
  logic [1:0]    ops_d [STACK_DEPTH];

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_slot
    logic [1:0] pop1_src, pop2_src, push_src, sel;

    if (g + 1 < STACK_DEPTH) begin : g_p1
      assign pop1_src = ops_q[g+1];
    end else begin : g_p1_end
      assign pop1_src = ops_q[g];
    end

    if (g + 2 < STACK_DEPTH) begin : g_p2
      assign pop2_src = ops_q[g+2];
    end else begin : g_p2_end
      assign pop2_src = ops_q[g];
    end

    if (g > 0) begin : g_ps
      assign push_src = ops_q[g-1];
    end else begin : g_ps_top
      assign push_src = ops_q[g];
    end

    always_comb begin
      unique case (oupd_i.shift)
        OSH_POP2: sel = pop2_src;
        OSH_POP1: sel = pop1_src;
        OSH_PUSH: sel = push_src;
        default:  sel = ops_q[g];
      endcase
    end

    if (g == 0) begin : g_top
      assign ops_d[g] = oupd_i.push ? oupd_i.code : sel;
    end else begin : g_rest
      assign ops_d[g] = sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (upd_i) begin
      cnt_q <= cnt_d_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      ops_q <= ops_d;
    end
  end

  assign cnt_o = cnt_q;
  assign top_o = {ops_q[2], ops_q[1], ops_q[0]};

endmodule

FILE: rtl/core/pmpe_eval.sv
module pmpe_eval #(
  parameter int unsigned STACK_DEPTH = 64,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  pmpe_pkg::in_t                     in_i,
  input  logic [CW-1:0]                     vcnt_i,
  input  logic [3:0][pmpe_pkg::VAL_W-1:0]   vwin_i,
  input  logic [CW-1:0]                     ocnt_i,
  input  logic [2:0][1:0]                   otop_i,
  input  logic [pmpe_pkg::VAL_W-1:0]        pend_i,
  input  logic                              pv_i,
  input  logic                              err_i,
  output logic [CW-1:0]                     vcnt_d_o,
  output pmpe_pkg::vupd_t                   vupd_o,
  output logic [CW-1:0]                     ocnt_d_o,
  output pmpe_pkg::oupd_t                   oupd_o,
  output logic [pmpe_pkg::VAL_W-1:0]        pend_d_o,
  output logic                              pv_d_o,
  output logic                              err_d_o,
  output pmpe_pkg::out_t                    res_o
);

  import pmpe_pkg::*;

  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  // small window onto the tops of both stacks; deeper entries are untouched
  typedef struct packed {
    logic [CW-1:0]         vcnt;
    logic [3:0][VAL_W-1:0] vw;
    logic [CW-1:0]         ocnt;
    logic [2:0][1:0]       ow;
    logic                  err;
    logic                  opush;
  } sim_t;

  function automatic sim_t vpush(sim_t s, logic [VAL_W-1:0] v);
    sim_t r;
    r = s;
    if (s.vcnt < FULL) begin
      r.vw[3] = s.vw[2];
      r.vw[2] = s.vw[1];
      r.vw[1] = s.vw[0];
      r.vw[0] = v;
      r.vcnt  = s.vcnt + CW'(1);
    end else begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  function automatic sim_t vpop(sim_t s);
    sim_t r;
    r = s;
    if (s.vcnt == '0) begin
      r.err = 1'b1;
    end else begin
      r.vw[0] = s.vw[1];
      r.vw[1] = s.vw[2];
      r.vw[2] = s.vw[3];
      r.vw[3] = '0;
      r.vcnt  = s.vcnt - CW'(1);
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] vpeek(sim_t s);
    return (s.vcnt == '0) ? '0 : s.vw[0];
  endfunction

  function automatic sim_t opush(sim_t s, logic [1:0] c);
    sim_t r;
    r = s;
    if (s.ocnt < FULL) begin
      r.ow[2] = s.ow[1];
      r.ow[1] = s.ow[0];
      r.ow[0] = c;
      r.ocnt  = s.ocnt + CW'(1);
      r.opush = 1'b1;
    end else begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  function automatic sim_t opop(sim_t s);
    sim_t r;
    r = s;
    if (s.ocnt == '0) begin
      r.err = 1'b1;
    end else begin
      r.ow[0] = s.ow[1];
      r.ow[1] = s.ow[2];
      r.ocnt  = s.ocnt - CW'(1);
    end
    return r;
  endfunction

  // empty operator stack reads as plus
  function automatic logic [1:0] opeek(sim_t s);
    return (s.ocnt == '0) ? OPC_PLUS : s.ow[0];
  endfunction

  function automatic logic arith_top(sim_t s);
    return (s.ocnt != '0) && (s.ow[0] != OPC_OPEN);
  endfunction

  function automatic sim_t apply_top(sim_t s);
    sim_t             r;
    logic [VAL_W-1:0] rhs, lhs;
    logic [1:0]       code;
    r    = s;
    rhs  = vpeek(r);
    r    = vpop(r);
    lhs  = vpeek(r);
    r    = vpop(r);
    code = opeek(r);
    r    = opop(r);
    r    = vpush(r, (code == OPC_PLUS) ? lhs + rhs : lhs - rhs);
    return r;
  endfunction

  always_comb begin
    sim_t             s;
    logic [VAL_W-1:0] p;
    logic             pv;
    logic             is_digit;
    logic [VAL_W-1:0] result;

    s.vcnt  = vcnt_i;
    s.vw    = vwin_i;
    s.ocnt  = ocnt_i;
    s.ow    = otop_i;
    s.err   = err_i;
    s.opush = 1'b0;
    p       = pend_i;
    pv      = pv_i;
    result  = '0;

    is_digit = (in_i.char_code >= CH_ZERO) && (in_i.char_code <= CH_NINE);

    if (is_digit) begin
      p  = p * DEC_RADIX + {{(VAL_W-8){1'b0}}, in_i.char_code - CH_ZERO};
      pv = 1'b1;
    end else begin
      if (pv) begin
        s  = vpush(s, p);
        p  = '0;
        pv = 1'b0;
      end
      unique case (in_i.char_code) inside
        CH_SPACE: begin
        end
        CH_PLUS, CH_MINUS: begin
          if (arith_top(s)) begin
            s = apply_top(s);
          end
          s = opush(s, (in_i.char_code == CH_PLUS) ? OPC_PLUS : OPC_MINUS);
        end
        CH_OPEN: begin
          s = opush(s, OPC_OPEN);
        end
        default: begin
          // anything else closes a group
          if (s.ocnt == '0) begin
            s.err = 1'b1;
          end else begin
            if (arith_top(s)) begin
              s = apply_top(s);
            end
            s = opop(s);
          end
        end
      endcase
    end

    if (in_i.last) begin
      if (pv) begin
        s  = vpush(s, p);
        p  = '0;
        pv = 1'b0;
      end
      if (s.ocnt != '0) begin
        s = apply_top(s);
      end
      if (s.vcnt == '0) begin
        s.err = 1'b1;
      end else begin
        result = s.vw[0];
      end
    end

    res_o.value = $signed(result);
    res_o.error = s.err;

    if (in_i.last) begin
      // back to the reset state: one zero value, no operators
      vcnt_d_o      = CW'(1);
      vupd_o.top    = '0;
      vupd_o.spill  = '0;
      ocnt_d_o      = '0;
      oupd_o.push   = 1'b0;
      oupd_o.code   = OPC_PLUS;
      oupd_o.shift  = OSH_HOLD;
      pend_d_o      = '0;
      pv_d_o        = 1'b0;
      err_d_o       = 1'b0;
    end else begin
      vcnt_d_o      = s.vcnt;
      vupd_o.top    = s.vw[2:0];
      vupd_o.spill  = s.vw[3];
      ocnt_d_o      = s.ocnt;
      oupd_o.push   = s.opush;
      oupd_o.code   = opc_e'(s.ow[0]);
      if (s.ocnt == ocnt_i + CW'(1)) begin
        oupd_o.shift = OSH_PUSH;
      end else if (s.ocnt == ocnt_i) begin
        oupd_o.shift = OSH_HOLD;
      end else if (s.ocnt == ocnt_i - CW'(1)) begin
        oupd_o.shift = OSH_POP1;
      end else begin
        oupd_o.shift = OSH_POP2;
      end
      pend_d_o      = p;
      pv_d_o        = pv;
      err_d_o       = s.err;
    end
  end

endmodule

FILE: dv/pmpe_result_checker.sv
module pmpe_result_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  pmpe_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  pmpe_pkg::out_t out_data_i,
  output int unsigned    fail_cnt_o,
  output int unsigned    due_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pmpe_pkg::*;

  // evaluator state, mirrored from the words seen on the input channel
  opc_e             op_stk  [DEPTH];
  logic [VAL_W-1:0] num_stk [DEPTH];
  int unsigned      op_cnt;
  int unsigned      num_cnt;
  logic [VAL_W-1:0] acc;
  logic             acc_vld;
  logic             stack_err;

  out_t results_due [$];

  function automatic void eval_clear();
    num_stk[0] = '0;
    num_cnt    = 1;
    op_cnt     = 0;
    acc        = '0;
    acc_vld    = 1'b0;
    stack_err  = 1'b0;
  endfunction

  function automatic void push_num(logic [VAL_W-1:0] v);
    if (num_cnt < DEPTH) begin
      num_stk[num_cnt] = v;
      num_cnt++;
    end else begin
      stack_err = 1'b1;
    end
  endfunction

  function automatic logic [VAL_W-1:0] pop_num();
    if (num_cnt == 0) begin
      stack_err = 1'b1;
      return '0;
    end
    num_cnt--;
    return num_stk[num_cnt];
  endfunction

  function automatic void push_op(opc_e c);
    if (op_cnt < DEPTH) begin
      op_stk[op_cnt] = c;
      op_cnt++;
    end else begin
      stack_err = 1'b1;
    end
  endfunction

  // empty stack yields plus
  function automatic opc_e pop_op();
    if (op_cnt == 0) begin
      stack_err = 1'b1;
      return OPC_PLUS;
    end
    op_cnt--;
    return op_stk[op_cnt];
  endfunction

  function automatic logic top_arith();
    return op_cnt > 0 && op_stk[op_cnt-1] != OPC_OPEN;
  endfunction

  // an open paren on top at the end counts as minus
  function automatic void apply_top();
    logic [VAL_W-1:0] rhs;
    logic [VAL_W-1:0] lhs;
    opc_e             c;
    rhs = pop_num();
    lhs = pop_num();
    c   = pop_op();
    push_num(c == OPC_PLUS ? lhs + rhs : lhs - rhs);
  endfunction

  function automatic void flush_acc();
    if (acc_vld) begin
      push_num(acc);
      acc     = '0;
      acc_vld = 1'b0;
    end
  endfunction

  function automatic void eval_char(in_t w);
    out_t res;
    if (w.char_code >= CH_ZERO && w.char_code <= CH_NINE) begin
      acc     = acc * DEC_RADIX + (VAL_W'(w.char_code) - VAL_W'(CH_ZERO));
      acc_vld = 1'b1;
    end else begin
      flush_acc();
      if (w.char_code == CH_PLUS || w.char_code == CH_MINUS) begin
        if (top_arith()) apply_top();
        if (w.char_code == CH_PLUS) push_op(OPC_PLUS);
        else push_op(OPC_MINUS);
      end else if (w.char_code == CH_OPEN) begin
        push_op(OPC_OPEN);
      end else if (w.char_code != CH_SPACE) begin
        // every other byte closes a paren
        if (op_cnt == 0) begin
          stack_err = 1'b1;
        end else begin
          if (top_arith()) apply_top();
          void'(pop_op());
        end
      end
    end
    if (w.last) begin
      flush_acc();
      if (op_cnt > 0) apply_top();
      if (num_cnt == 0) begin
        stack_err = 1'b1;
        res.value = '0;
      end else begin
        res.value = num_stk[num_cnt-1];
      end
      res.error = stack_err;
      results_due.push_back(res);
      eval_clear();
    end
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      eval_clear();
      results_due.delete();
      fail_cnt_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result word with none due: value %0d error %0b",
                 out_data_i.value, out_data_i.error);
          fail_cnt_o++;
        end else begin
          want = results_due.pop_front();
          if (out_data_i.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_data_i.value);
            fail_cnt_o++;
          end
          if (out_data_i.error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, out_data_i.error);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) eval_char(in_data_i);
    end
    due_cnt_o = results_due.size();
  end

endmodule

FILE: dv/tb_plus_minus_paren_evaluator.sv
module tb_plus_minus_paren_evaluator;
  timeunit 1ns;
  timeprecision 1ps;
  import pmpe_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CHAR_BUDGET = 1450;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam logic [7:0]  CH_CLOSE    = 8'h29;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_RUNS
  } rx_mode_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  int unsigned fail_cnt;
  int unsigned due_cnt;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned sent = 0;
  logic [7:0]  expr_q [$];

  plus_minus_paren_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  pmpe_result_checker #(
    .DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .fail_cnt_o (fail_cnt),
    .due_cnt_o  (due_cnt)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("plus_minus_paren_evaluator verification failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] sign_char();
    return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
  endfunction

  // any byte that the block treats as a close
  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_OPEN || c == CH_SPACE);
    return c;
  endfunction

  // 0x2F and 0x3A sit just outside the digit range
  function automatic logic [7:0] noise_char();
    logic [7:0] picks [10] = '{CH_ZERO, CH_NINE, CH_PLUS, CH_MINUS, CH_OPEN, CH_SPACE,
                               CH_CLOSE, 8'h2F, 8'h3A, 8'hFF};
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return picks[$urandom_range(0, 9)];
  endfunction

  function automatic void add_space();
    if ($urandom_range(0, 4) == 0) expr_q.push_back(CH_SPACE);
  endfunction

  function automatic void add_digit();
    expr_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // now and then long enough to wrap
  function automatic void add_number();
    int unsigned ndig;
    ndig = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
    repeat (ndig) add_digit();
  endfunction

  function automatic void add_close();
    expr_q.push_back(($urandom_range(0, 5) == 0) ? stray_char() : CH_CLOSE);
  endfunction

  function automatic void add_sum(int unsigned terms);
    int unsigned depth = 0;
    if ($urandom_range(0, 5) == 0) expr_q.push_back(sign_char());
    for (int unsigned t = 0; t < terms; t++) begin
      if (t != 0) begin
        add_space();
        expr_q.push_back(sign_char());
        add_space();
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          expr_q.push_back(CH_OPEN);
          depth++;
          if ($urandom_range(0, 4) == 0) expr_q.push_back(sign_char());
        end
      end
      add_number();
      add_space();
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        add_close();
        depth--;
      end
    end
    // sometimes leave parens open
    while (depth > 0 && $urandom_range(0, 7) != 0) begin
      add_close();
      depth--;
    end
  endfunction

  function automatic void mangle();
    int unsigned pos;
    repeat ($urandom_range(1, 2)) begin
      pos = $urandom_range(0, expr_q.size() - 1);
      case ($urandom_range(0, 2))
        0: if (expr_q.size() > 1) expr_q.delete(pos);
        1: expr_q[pos] = noise_char();
        default: expr_q.insert(pos, $urandom_range(0, 1) ? CH_CLOSE : sign_char());
      endcase
    end
  endfunction

  // runs up to or past the stack depth
  function automatic void add_deep();
    case ($urandom_range(0, 2))
      0: begin
        repeat ($urandom_range(60, 70)) expr_q.push_back(CH_OPEN);
        add_number();
        repeat ($urandom_range(0, 3)) add_close();
      end
      1: begin
        repeat ($urandom_range(60, 68)) begin
          add_digit();
          expr_q.push_back(CH_SPACE);
        end
      end
      default: begin
        repeat ($urandom_range(30, 36)) begin
          expr_q.push_back(CH_OPEN);
          add_digit();
          expr_q.push_back(sign_char());
        end
      end
    endcase
  endfunction

  function automatic void load(string s);
    expr_q.delete();
    foreach (s[i]) expr_q.push_back(s[i]);
  endfunction

  // entered and left at a falling edge
  task automatic put_word(logic [7:0] ch, logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_code: ch, last: lst};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) begin
      sent++;
      put_word(expr_q[i], i == expr_q.size() - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (due_cnt != 0);
  endtask

  initial begin : rx_stall
    rx_mode_e    mode;
    int unsigned hold;
    logic        rdy;
    out_ready = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      hold = 0;
      rdy  = 1'b1;
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   rdy = 1'b1;
          RX_COIN:   rdy = 1'($urandom_range(0, 1));
          RX_SPARSE: rdy = ($urandom_range(0, 7) == 0);
          default: begin
            if (hold == 0) begin
              rdy  = !rdy;
              hold = rdy ? $urandom_range(1, 12) : $urandom_range(1, 20);
            end
            hold--;
          end
        endcase
        out_ready <= rdy;
      end
    end
  end

  initial begin : stim
    int unsigned pick;
    logic        mid_drained;
    mid_drained = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load(" ");
    send_expr();
    load("7");
    expr_q.push_back(8'hFF);  // close with nothing open
    send_expr();
    load("1+");
    expr_q.push_back(8'h00);  // close drains the operator stack
    send_expr();
    load("-9(");              // open left at the end subtracts
    send_expr();
    load("++");               // value stack runs dry
    send_expr();
    load("8-(3+1)");
    send_expr();
    load("9000000000");
    send_expr();
    drain();

    while (sent < CHAR_BUDGET) begin
      expr_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_sum($urandom_range(1, 6));
      end else if (pick < 84) begin
        add_sum($urandom_range(1, 4));
        mangle();
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 10)) expr_q.push_back(noise_char());
      end else begin
        add_deep();
      end
      send_expr();
      if (!mid_drained && sent >= CHAR_BUDGET / 2) begin
        drain();
        mid_drained = 1'b1;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) $display("plus_minus_paren_evaluator verification clean");
    else $display("plus_minus_paren_evaluator verification failed");
    $finish;
  end

endmodule
